// ===== rtl/mck_pkg.sv =====
// Shared types, constants and character lookup for the Morse keyer.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package mck_pkg;

    localparam int CHAR_W  = 8;
    localparam int BEAT_W  = 16;
    localparam int DUR_W   = 19;
    localparam int CODE_W  = 6;
    localparam int PAT_W   = 5;
    localparam int CNT_W   = 3;
    localparam int TDATA_W = 24;

    localparam logic [BEAT_W-1:0] BEAT_RESET = 16'd1000;

    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_D0    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_D9    = 8'h39;

    // Leading one marks the start, then one bit per element, MSB first, 1 = dash.
    localparam logic [CODE_W-1:0] LETTER_CODE [26] = '{
        6'd5,  6'd24, 6'd26, 6'd12, 6'd2,  6'd18, 6'd14, 6'd16, 6'd4,
        6'd23, 6'd13, 6'd20, 6'd7,  6'd6,  6'd15, 6'd22, 6'd29, 6'd10,
        6'd8,  6'd3,  6'd9,  6'd17, 6'd11, 6'd25, 6'd27, 6'd28
    };
    localparam logic [CODE_W-1:0] DIGIT_CODE [10] = '{
        6'd63, 6'd47, 6'd39, 6'd35, 6'd33, 6'd32, 6'd48, 6'd56, 6'd60, 6'd62
    };

    typedef enum logic [1:0] {
        BEATS_1 = 2'd0,
        BEATS_2 = 2'd1,
        BEATS_3 = 2'd2,
        BEATS_6 = 2'd3
    } beats_t;

    typedef struct packed {
        logic   load;
        logic   emit;
        logic   advance;
        logic   tone;
        beats_t beats;
        logic   last;
    } dp_cmd_t;

    typedef struct packed {
        logic space;
        logic mapped;
        logic dash;
        logic cnt_last;
        logic slot_free;
    } dp_status_t;

    // Pattern code of a character, zero when the character has none.
    function automatic logic [CODE_W-1:0] char_pattern(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] diff_l;
        logic [CHAR_W-1:0] diff_u;
        logic [CHAR_W-1:0] diff_d;
        logic [CODE_W-1:0] code;
        diff_l = c - CHAR_LA;
        diff_u = c - CHAR_UA;
        diff_d = c - CHAR_D0;
        code   = '0;
        if (c >= CHAR_LA && c <= CHAR_LZ)
            code = LETTER_CODE[diff_l[4:0]];
        else if (c >= CHAR_UA && c <= CHAR_UZ)
            code = LETTER_CODE[diff_u[4:0]];
        else if (c >= CHAR_D0 && c <= CHAR_D9)
            code = DIGIT_CODE[diff_d[3:0]];
        return code;
    endfunction

    // Number of elements: position of the start marker.
    function automatic logic [CNT_W-1:0] pattern_len(input logic [CODE_W-1:0] code);
        logic [CNT_W-1:0] len;
        len = '0;
        for (int b = 1; b <= PAT_W; b++)
        begin
            if (code[b])
                len = CNT_W'(b);
        end
        return len;
    endfunction

endpackage

// ===== rtl/mck_datapath.sv =====
// Datapath of the Morse keyer: beat register, element shifter, element
// counter and the output segment register. Depends on mck_pkg.
module mck_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [mck_pkg::BEAT_W-1:0]    cfg_data,
    input  logic [mck_pkg::CHAR_W-1:0]    char_code,
    input  logic                          m_tready,
    input  mck_pkg::dp_cmd_t              cmd,
    output mck_pkg::dp_status_t           status,
    output logic                          m_tvalid,
    output logic                          tone_on,
    output logic [mck_pkg::DUR_W-1:0]     duration_ticks,
    output logic                          last_segment
);

    logic [mck_pkg::BEAT_W-1:0] beat_reg;
    logic [mck_pkg::PAT_W-1:0]  pat_reg,  pat_next;
    logic [mck_pkg::CNT_W-1:0]  cnt_reg,  cnt_next;
    logic                       valid_reg, valid_next;
    logic                       tone_reg;
    logic [mck_pkg::DUR_W-1:0]  dur_reg,  dur_next;
    logic                       last_reg;

    logic [mck_pkg::CODE_W-1:0] in_code;
    logic [mck_pkg::CNT_W-1:0]  in_len;
    logic [mck_pkg::DUR_W-1:0]  beat_x1;
    logic [mck_pkg::DUR_W-1:0]  beat_x2;
    logic [mck_pkg::DUR_W-1:0]  beat_x3;

    assign in_code = mck_pkg::char_pattern(char_code);
    assign in_len  = mck_pkg::pattern_len(in_code);

    assign status.space     = (char_code == mck_pkg::SPACE_CODE);
    assign status.mapped    = (in_code != '0);
    assign status.dash      = pat_reg[mck_pkg::PAT_W-1];
    assign status.cnt_last  = (cnt_reg == mck_pkg::CNT_W'(1));
    assign status.slot_free = !valid_reg || m_tready;

    assign beat_x1 = mck_pkg::DUR_W'(beat_reg);
    assign beat_x2 = beat_x1 << 1;
    assign beat_x3 = beat_x1 + beat_x2;

    always_comb
    begin
        unique case (cmd.beats)
            mck_pkg::BEATS_1: dur_next = beat_x1;
            mck_pkg::BEATS_2: dur_next = beat_x2;
            mck_pkg::BEATS_3: dur_next = beat_x3;
            mck_pkg::BEATS_6: dur_next = beat_x3 << 1;
            default:          dur_next = beat_x1;
        endcase
    end

    always_comb
    begin
        pat_next = pat_reg;
        cnt_next = cnt_reg;
        priority if (cmd.load)
        begin
            // left-align the elements so the next one is always in the MSB
            pat_next = mck_pkg::PAT_W'(in_code[mck_pkg::PAT_W-1:0]
                                       << (mck_pkg::CNT_W'(mck_pkg::PAT_W) - in_len));
            cnt_next = in_len;
        end
        else if (cmd.advance)
        begin
            pat_next = pat_reg << 1;
            cnt_next = cnt_reg - mck_pkg::CNT_W'(1);
        end
        else
        begin
            pat_next = pat_reg;
            cnt_next = cnt_reg;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        priority if (cmd.emit)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg  <= mck_pkg::BEAT_RESET;
            pat_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                beat_reg <= cfg_data;
            pat_reg   <= pat_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            tone_reg <= cmd.tone;
            dur_reg  <= dur_next;
            last_reg <= cmd.last;
        end
    end

    assign m_tvalid       = valid_reg;
    assign tone_on        = tone_reg;
    assign duration_ticks = dur_reg;
    assign last_segment   = last_reg;

endmodule

// ===== rtl/mck_ctrl.sv =====
// Controller of the Morse keyer: walks one character through its element
// and gap segments. Depends on mck_pkg; drives mck_datapath by commands.
module mck_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mck_pkg::dp_status_t status,
    output mck_pkg::dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ON    = 5'b00010,
        S_OFF   = 5'b00100,
        S_GAP   = 5'b01000,
        S_SPACE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.beats   = mck_pkg::BEATS_1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    // drop an unmapped character: stay idle
                    priority if (status.space)
                        state_next = S_SPACE;
                    else if (status.mapped)
                        state_next = S_ON;
                    else
                        state_next = S_IDLE;
                end
            end
            S_ON:
            begin
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.tone   = 1'b1;
                    cmd.beats  = status.dash ? mck_pkg::BEATS_3 : mck_pkg::BEATS_1;
                    state_next = S_OFF;
                end
            end
            S_OFF:
            begin
                if (status.slot_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.advance = 1'b1;
                    state_next  = status.cnt_last ? S_GAP : S_ON;
                end
            end
            S_GAP:
            begin
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.beats  = mck_pkg::BEATS_2;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SPACE:
            begin
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.beats  = mck_pkg::BEATS_6;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/morse_character_keyer.sv =====
// Morse character keyer, top level: wires the controller to the datapath.
// Depends on mck_pkg, mck_ctrl and mck_datapath.
//
// One ASCII character is accepted per input transaction and becomes a run of
// key segments on the output stream, one segment per output transaction; the
// last segment of a character carries tlast. A character yields 2 * elements
// plus 1 segments: 11 for a five-element digit, 1 for a space and none for an
// unmapped code. The controller issues one segment per cycle into a single
// output register while that register is free, so output backpressure holds
// it back. The next character is taken only once the last segment of the
// current one sits in the output register. beat_ticks resets to 1000 and is
// written through the cfg channel, which is always ready.
module morse_character_keyer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mck_pkg::BEAT_W-1:0]    cfg_data,      // beat_ticks
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mck_pkg::CHAR_W-1:0]    s_axis_tdata,  // [7:0] char_code
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mck_pkg::TDATA_W-1:0]   m_axis_tdata,  // [18:0] duration_ticks, rest zero
    output logic                          m_axis_tuser,  // [0] tone_on
    output logic                          m_axis_tlast
);

    mck_pkg::dp_cmd_t           cmd;
    mck_pkg::dp_status_t        status;
    logic [mck_pkg::DUR_W-1:0]  duration_ticks;

    assign cfg_ready = 1'b1;

    mck_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mck_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .char_code      (s_axis_tdata),
        .m_tready       (m_axis_tready),
        .cmd            (cmd),
        .status         (status),
        .m_tvalid       (m_axis_tvalid),
        .tone_on        (m_axis_tuser),
        .duration_ticks (duration_ticks),
        .last_segment   (m_axis_tlast)
    );

    assign m_axis_tdata = {{(mck_pkg::TDATA_W - mck_pkg::DUR_W){1'b0}}, duration_ticks};

endmodule

// ===== rtl/mck_checker.sv =====
// Port-level checker for the Morse keyer, bound to the top level.
// Depends on mck_pkg and morse_character_keyer.
module mck_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [mck_pkg::CHAR_W-1:0]    s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [mck_pkg::TDATA_W-1:0]   m_axis_tdata,
    input  logic                          m_axis_tuser,
    input  logic                          m_axis_tlast
);

    // hold a stalled segment
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output segment changed");

    // a tone segment is always followed by its element gap
    a_tone_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser && m_axis_tlast))
        else $error("tone segment marked as last");

    // no new character while one is still being keyed
    a_busy_mid_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready in the middle of a character");

    // a space transaction blocks input until its gap is issued
    a_space_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata == mck_pkg::SPACE_CODE)
            |=> !s_axis_tready)
        else $error("space did not occupy the keyer");

endmodule

bind morse_character_keyer mck_checker u_mck_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/morse_character_keyer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for morse_character_keyer: streams characters in, predicts the
// key segments from its own table of Morse patterns and checks every output transaction.
// Depends on mck_pkg and the keyer RTL.
module morse_character_keyer_tb;

    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 6;
    localparam int SETTLE_CYCLES    = 16;
    localparam int DRAIN_LIMIT      = 2000;
    localparam int NUM_PHASES       = 7;
    localparam int RANDOM_PER_PHASE = 50;
    localparam int WATCHDOG_NS      = 8_000_000;

    localparam int DOT_BEATS         = 1;
    localparam int DASH_BEATS        = 3;
    localparam int ELEMENT_GAP_BEATS = 1;
    localparam int LETTER_GAP_BEATS  = 2;
    localparam int WORD_GAP_BEATS    = 6;

    localparam logic TONE_ON  = 1'b1;
    localparam logic TONE_OFF = 1'b0;
    localparam byte  DASH_MARK = "-";

    typedef struct packed {
        logic                      tone;
        logic [mck_pkg::DUR_W-1:0] ticks;
        logic                      last;
    } segment_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [mck_pkg::BEAT_W-1:0]   cfg_data = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [mck_pkg::CHAR_W-1:0]   s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [mck_pkg::TDATA_W-1:0]  m_axis_tdata;
    logic                         m_axis_tuser;
    logic                         m_axis_tlast;

    logic [mck_pkg::CHAR_W-1:0]   chars_pending [$];
    segment_t                     segments_due [$];
    segment_t                     seg_due;
    logic [mck_pkg::BEAT_W-1:0]   beat_len = mck_pkg::BEAT_RESET;
    int                           chars_queued = 0;
    int                           chars_taken = 0;
    int                           send_hold = 0;
    int                           recv_hold = 0;
    int                           recv_stall;
    int                           mismatches = 0;
    int                           missing = 0;
    bit                           steady_phase = 1'b0;

    morse_character_keyer uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #HALF_PERIOD clk = ~clk;

    // Dots and dashes of an upper-case letter or a digit; empty when unmapped.
    function automatic string morse_pattern(input logic [mck_pkg::CHAR_W-1:0] ch);
        case (ch)
            "A": return ".-";     "B": return "-...";   "C": return "-.-.";
            "D": return "-..";    "E": return ".";      "F": return "..-.";
            "G": return "--.";    "H": return "....";   "I": return "..";
            "J": return ".---";   "K": return "-.-";    "L": return ".-..";
            "M": return "--";     "N": return "-.";     "O": return "---";
            "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
            "S": return "...";    "T": return "-";      "U": return "..-";
            "V": return "...-";   "W": return ".--";    "X": return "-..-";
            "Y": return "-.--";   "Z": return "--..";
            "0": return "-----";  "1": return ".----";  "2": return "..---";
            "3": return "...--";  "4": return "....-";  "5": return ".....";
            "6": return "-....";  "7": return "--...";  "8": return "---..";
            "9": return "----.";
            default: return "";
        endcase
    endfunction

    function automatic void push_segment(input logic tone, input int beats, input logic last);
        segment_t seg;
        seg.tone  = tone;
        seg.ticks = mck_pkg::DUR_W'(beat_len) * mck_pkg::DUR_W'(beats);
        seg.last  = last;
        segments_due.push_back(seg);
    endfunction

    function automatic void key_character(input logic [mck_pkg::CHAR_W-1:0] ch);
        string                      pattern;
        logic [mck_pkg::CHAR_W-1:0] upper;
        upper = ch;
        if (ch >= mck_pkg::CHAR_LA && ch <= mck_pkg::CHAR_LZ)
            upper = ch - (mck_pkg::CHAR_LA - mck_pkg::CHAR_UA);
        if (ch == mck_pkg::SPACE_CODE)
        begin
            push_segment(TONE_OFF, WORD_GAP_BEATS, 1'b1);
            return;
        end
        pattern = morse_pattern(upper);
        for (int i = 0; i < pattern.len(); i++)
        begin
            push_segment(TONE_ON, (pattern[i] == DASH_MARK) ? DASH_BEATS : DOT_BEATS, 1'b0);
            push_segment(TONE_OFF, ELEMENT_GAP_BEATS, 1'b0);
        end
        if (pattern.len() > 0)
            push_segment(TONE_OFF, LETTER_GAP_BEATS, 1'b1);
    endfunction

    // Mostly back to back (always so in a steady phase), some short gaps, a few long ones.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (steady_phase || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [mck_pkg::CHAR_W-1:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return mck_pkg::CHAR_UA + mck_pkg::CHAR_W'($urandom_range(0, 25));
        if (r < 60)
            return mck_pkg::CHAR_LA + mck_pkg::CHAR_W'($urandom_range(0, 25));
        if (r < 75)
            return mck_pkg::CHAR_D0 + mck_pkg::CHAR_W'($urandom_range(0, 9));
        if (r < 85)
            return mck_pkg::SPACE_CODE;
        return mck_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic queue_char(input logic [mck_pkg::CHAR_W-1:0] ch);
        chars_pending.push_back(ch);
        chars_queued++;
    endtask

    // Hold until every character is taken and every segment has come out or the drain limit runs out.
    task automatic wait_idle();
        int waited;
        waited = 0;
        while (chars_taken != chars_queued)
            @(posedge clk);
        while (segments_due.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (segments_due.size() > 0)
        begin
            $display("%0t: %0d expected segments never arrived", $time, segments_due.size());
            missing++;
            segments_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_beat(input logic [mck_pkg::BEAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        beat_len = value;
    endtask

    // Input side: one character per transaction, gaps drawn after each send.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_hold     <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                key_character(s_axis_tdata);
                chars_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_hold > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    send_hold     <= send_hold - 1;
                end
                else if (chars_pending.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= chars_pending.pop_front();
                    send_hold     <= idle_cycles();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: check each segment against the oldest prediction, then maybe stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_hold     <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (segments_due.size() == 0)
                begin
                    $display("%0t: expected no segment, actual tone=%0b ticks=%0d last=%0b",
                             $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    seg_due = segments_due.pop_front();
                    if (m_axis_tuser !== seg_due.tone)
                    begin
                        $display("%0t: tone_on expected %0b actual %0b", $time,
                                 seg_due.tone, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata !== mck_pkg::TDATA_W'(seg_due.ticks))
                    begin
                        $display("%0t: duration_ticks expected %0d actual %0d", $time,
                                 seg_due.ticks, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tlast !== seg_due.last)
                    begin
                        $display("%0t: last_segment expected %0b actual %0b", $time,
                                 seg_due.last, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            if (recv_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_hold     <= recv_hold - 1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                recv_stall = idle_cycles();
                m_axis_tready <= (recv_stall == 0);
                recv_hold     <= (recv_stall > 0) ? recv_stall - 1 : 0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        logic [mck_pkg::CHAR_W-1:0] directed_chars [$];
        logic [mck_pkg::BEAT_W-1:0] setting;
        directed_chars = '{"E", "T", "A", "Z", "a", "z", "0", "9", "5", " ", "Q", "Y",
                           "@", "[", 8'h60, "{", "/", ":", 8'h00, 8'h7F, 8'hFF, 8'hA0,
                           "h", "m"};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            steady_phase = (phase == 2 || phase == 5);
            case (phase)
                0:       setting = mck_pkg::BEAT_RESET;
                1:       setting = 16'd1;
                2:       setting = 16'hFFFF;
                3:       setting = 16'd0;
                4:       setting = 16'd3;
                default: setting = mck_pkg::BEAT_W'($urandom_range(1, 65535));
            endcase
            // Phase 0 runs on the reset value of the beat length.
            if (phase > 0)
                write_beat(setting);
            if (phase == 0)
                foreach (directed_chars[i])
                    queue_char(directed_chars[i]);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                queue_char(random_char());
            wait_idle();
        end
        if (mismatches == 0 && missing == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #WATCHDOG_NS;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mck_pkg.sv
rtl/mck_datapath.sv
rtl/mck_ctrl.sv
rtl/morse_character_keyer.sv
rtl/mck_checker.sv
verif/morse_character_keyer_tb.sv
